[hw/rtl/pfa_pkg.sv]
// pfa_pkg: shared constants, types and row helpers for the page frame allocator
`timescale 1ns / 1ps

package pfa_pkg;

  // page space
  localparam int NUM_PAGES = 65536;
  localparam int PAGE_AW   = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_AW + 1;

  // field widths
  localparam int REQ_W    = 2;
  localparam int PAGE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 17;
  localparam int LIMIT_W  = 17;
  localparam int HINT_W   = 16;

  // limit and hint registers cover both the field and the page space
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // page state store: one row holds the states of ROW_PAGES pages
  localparam int PS_W      = 2;
  localparam int ROW_SHIFT = 4;
  localparam int ROW_PAGES = 1 << ROW_SHIFT;
  localparam int ROW_DW    = ROW_PAGES * PS_W;
  localparam int NUM_ROWS  = NUM_PAGES / ROW_PAGES;
  localparam int ROW_AW    = $clog2(NUM_ROWS);

  // reset values
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(65536);
  localparam logic [LIM_W-1:0] NUM_PAGES_L = LIM_W'(NUM_PAGES);
  localparam logic [LIM_W-1:0] LIM_RESET_EFF =
    (LIMIT_RESET > NUM_PAGES_L) ? NUM_PAGES_L : LIMIT_RESET;
  localparam logic [LIM_W-1:0] HINT_RESET = LIM_W'(32'h100);

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HINT_START = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC       = 2'd0,
    REQ_FREE        = 2'd1,
    REQ_MARK_FREE   = 2'd2,
    REQ_MARK_KERNEL = 2'd3
  } req_t;

  typedef enum logic [PS_W-1:0] {
    PS_RESERVED = 2'd0,
    PS_KERNEL   = 2'd1,
    PS_FREE     = 2'd2,
    PS_INUSE    = 2'd3
  } pstate_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_NOT_INUSE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [ROW_DW-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic                 hit;
    logic [ROW_SHIFT-1:0] slot;
  } find_t;

  typedef struct packed {
    status_t              status;
    logic [PAGE_W-1:0]    page;
    logic [COUNT_W-1:0]   free_cnt;
    logic [COUNT_W-1:0]   total_cnt;
  } result_t;

  // state of one page within a row
  function automatic pstate_t get_slot(input logic [ROW_DW-1:0] row,
                                       input logic [ROW_SHIFT-1:0] slot);
    return pstate_t'(row[{slot, 1'b0} +: PS_W]);
  endfunction

  // row with one page state replaced
  function automatic logic [ROW_DW-1:0] set_slot(input logic [ROW_DW-1:0] row,
                                                 input logic [ROW_SHIFT-1:0] slot,
                                                 input pstate_t ps);
    logic [ROW_DW-1:0] r;
    r = row;
    r[{slot, 1'b0} +: PS_W] = ps;
    return r;
  endfunction

endpackage

[hw/rtl/page_frame_allocator_core.sv]
// page_frame_allocator_core: top level with state store, sequencer and result register
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in_      | input     | in_valid / in_ready  | in_req_type, in_page_number
//  out_     | output    | out_valid / out_ready| out_status, out_page_out,
//           |           |                      | out_free_count, out_total_count
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// free, mark available and mark kernel read the row from the page state store, whose read
// port is registered, and write it back in S_MODIFY before the result; a page beyond the
// limit or an allocate with the hint past the limit goes straight from S_IDLE to S_DONE.
// allocate scans the 16-page rows from the hint row, one row a cycle, until a hit or the
// limit row. after reset a clearing pass writes all 4096 rows before in_ready rises;
// cfg_ready is always high. the result register frees the sequencer while out_ stalls.
`timescale 1ns / 1ps

module page_frame_allocator_core
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [PAGE_W-1:0]    in_page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [PAGE_W-1:0]    out_page_out,
  output logic [COUNT_W-1:0]   out_free_count,
  output logic [COUNT_W-1:0]   out_total_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  ram_rd_t           rd;
  ram_wr_t           wr;
  logic [ROW_DW-1:0] rd_data;
  cfg_wr_t           cfg;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;

  // configuration always taken
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  pfa_state_ram u_ram (
    .clk     (clk),
    .rd      (rd),
    .rd_data (rd_data),
    .wr      (wr)
  );

  pfa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_page_number (in_page_number),
    .cfg            (cfg),
    .rd             (rd),
    .rd_data        (rd_data),
    .wr             (wr),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // result register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_page_out    = out_r.page;
  assign out_free_count  = out_r.free_cnt;
  assign out_total_count = out_r.total_cnt;

endmodule

[hw/rtl/pfa_state_ram.sv]
// pfa_state_ram: page state store, one row of page states per address
`timescale 1ns / 1ps

module pfa_state_ram
  import pfa_pkg::*;
(
  input  logic              clk,
  input  ram_rd_t           rd,
  output logic [ROW_DW-1:0] rd_data,
  input  ram_wr_t           wr
);

  logic [ROW_DW-1:0] mem [NUM_ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[hw/rtl/pfa_row_find.sv]
// pfa_row_find: first free page of a row inside an optional slot window
`timescale 1ns / 1ps

module pfa_row_find
  import pfa_pkg::*;
(
  input  logic [ROW_DW-1:0]    row_data,
  input  logic                 lo_en,
  input  logic [ROW_SHIFT-1:0] lo_slot,
  input  logic                 hi_en,
  input  logic [ROW_SHIFT-1:0] hi_slot,
  output find_t                find
);

  // priority search, lowest eligible slot wins
  always_comb begin
    find.hit  = 1'b0;
    find.slot = '0;
    for (int j = ROW_PAGES - 1; j >= 0; j--) begin
      if (get_slot(row_data, ROW_SHIFT'(j)) == PS_FREE &&
          (!lo_en || ROW_SHIFT'(j) >= lo_slot) &&
          (!hi_en || ROW_SHIFT'(j) <= hi_slot)) begin
        find.hit  = 1'b1;
        find.slot = ROW_SHIFT'(j);
      end
    end
  end

endmodule

[hw/rtl/pfa_ctrl.sv]
// pfa_ctrl: request sequencer, counters, hint, limit and row read-modify-write
`timescale 1ns / 1ps

module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [PAGE_W-1:0] in_page_number,
  input  cfg_wr_t           cfg,
  output ram_rd_t           rd,
  input  logic [ROW_DW-1:0] rd_data,
  output ram_wr_t           wr,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  fsm_t              state_r, state_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [LIM_W-1:0]  hint_r, hint_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;
  logic [ROW_AW-1:0] scan_row_r, scan_row_nxt;
  logic [ROW_AW-1:0] chk_row_r, chk_row_nxt;
  req_t              req_r, req_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  result_t           res_r, res_nxt;

  logic                 accept;
  req_t                 in_req;
  logic                 in_beyond;
  logic                 hint_past;
  logic [LIM_W-1:0]     lim_m1;
  logic [ROW_AW-1:0]    last_row;
  logic [ROW_AW-1:0]    hint_row;
  logic [ROW_AW-1:0]    in_row;
  logic [ROW_AW-1:0]    page_row;
  logic [ROW_SHIFT-1:0] page_slot;
  pstate_t              cur_ps;
  find_t                find;
  logic                 scan_end;
  logic [PAGE_AW-1:0]   found_page;
  logic [LIM_W-1:0]     cfg_lim;

  // decode and address helpers
  assign accept     = in_valid && in_ready;
  assign in_req     = req_t'(in_req_type);
  assign in_beyond  = LIM_W'(in_page_number) >= lim_r;
  assign hint_past  = hint_r >= lim_r;
  assign lim_m1     = lim_r - LIM_W'(1);
  assign last_row   = ROW_AW'(lim_m1 >> ROW_SHIFT);
  assign hint_row   = ROW_AW'(hint_r >> ROW_SHIFT);
  assign in_row     = ROW_AW'(in_page_number >> ROW_SHIFT);
  assign page_row   = ROW_AW'(page_r >> ROW_SHIFT);
  assign page_slot  = page_r[ROW_SHIFT-1:0];
  assign cur_ps     = get_slot(rd_data, page_slot);
  assign scan_end   = find.hit || (chk_row_r == last_row);
  assign found_page = {chk_row_r, find.slot};
  assign cfg_lim    = (LIM_W'(cfg.data) > NUM_PAGES_L) ? NUM_PAGES_L : LIM_W'(cfg.data);

  // free page search over the row just read
  pfa_row_find u_find (
    .row_data (rd_data),
    .lo_en    (chk_row_r == hint_row),
    .lo_slot  (hint_r[ROW_SHIFT-1:0]),
    .hi_en    (chk_row_r == last_row),
    .hi_slot  (lim_m1[ROW_SHIFT-1:0]),
    .find     (find)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_row_r == ROW_AW'(NUM_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req == REQ_ALLOC) begin
            state_nxt = hint_past ? S_DONE : S_SCAN;
          end else begin
            state_nxt = in_beyond ? S_DONE : S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs: handshakes and memory ports
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd.en     = 1'b0;
    rd.addr   = in_row;
    wr.en     = 1'b0;
    wr.addr   = page_row;
    wr.data   = rd_data;
    case (state_r)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_row_r;
        wr.data = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        rd.en    = in_valid;
        rd.addr  = (in_req == REQ_ALLOC) ? hint_row : in_row;
      end
      S_MODIFY: begin
        wr.en   = 1'b1;
        wr.addr = page_row;
        case (req_r)
          REQ_FREE: begin
            if (cur_ps == PS_INUSE) begin
              wr.data = set_slot(rd_data, page_slot, PS_FREE);
            end
          end
          REQ_MARK_FREE: begin
            if (cur_ps == PS_RESERVED || cur_ps == PS_KERNEL) begin
              wr.data = set_slot(rd_data, page_slot, PS_FREE);
            end
          end
          REQ_MARK_KERNEL: begin
            wr.data = set_slot(rd_data, page_slot, PS_KERNEL);
          end
          default: begin
            wr.en = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        rd.en   = !scan_end;
        rd.addr = scan_row_r;
        wr.en   = find.hit;
        wr.addr = chk_row_r;
        wr.data = set_slot(rd_data, find.slot, PS_INUSE);
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    lim_nxt      = lim_r;
    hint_nxt     = hint_r;
    free_nxt     = free_r;
    total_nxt    = total_r;
    clr_row_nxt  = clr_row_r;
    scan_row_nxt = scan_row_r;
    chk_row_nxt  = chk_row_r;
    req_nxt      = req_r;
    page_nxt     = page_r;
    res_nxt      = res_r;
    case (state_r)
      S_CLEAR: begin
        clr_row_nxt = clr_row_r + ROW_AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt       = in_req;
          page_nxt      = in_page_number;
          chk_row_nxt   = hint_row;
          scan_row_nxt  = hint_row + ROW_AW'(1);
          res_nxt.page  = in_page_number;
          res_nxt.status = (in_req == REQ_ALLOC) ? ST_NO_FREE : ST_BEYOND;
          res_nxt.free_cnt  = COUNT_W'(free_r);
          res_nxt.total_cnt = COUNT_W'(total_r);
        end
      end
      S_MODIFY: begin
        res_nxt.status = ST_OK;
        case (req_r)
          REQ_FREE: begin
            if (cur_ps == PS_INUSE) begin
              free_nxt = free_r + CNT_W'(1);
              if (LIM_W'(page_r) < hint_r) begin
                hint_nxt = LIM_W'(page_r);
              end
            end else begin
              res_nxt.status = ST_NOT_INUSE;
            end
          end
          REQ_MARK_FREE: begin
            if (cur_ps == PS_RESERVED || cur_ps == PS_KERNEL) begin
              free_nxt  = free_r + CNT_W'(1);
              total_nxt = total_r + CNT_W'(1);
            end
          end
          REQ_MARK_KERNEL: begin
            if (cur_ps == PS_FREE) begin
              free_nxt  = free_r - CNT_W'(1);
              total_nxt = total_r - CNT_W'(1);
            end else if (cur_ps == PS_INUSE) begin
              total_nxt = total_r - CNT_W'(1);
            end
          end
          default: begin
            res_nxt.status = ST_OK;
          end
        endcase
        res_nxt.free_cnt  = COUNT_W'(free_nxt);
        res_nxt.total_cnt = COUNT_W'(total_nxt);
      end
      S_SCAN: begin
        chk_row_nxt  = scan_row_r;
        scan_row_nxt = scan_row_r + ROW_AW'(1);
        if (find.hit) begin
          free_nxt          = free_r - CNT_W'(1);
          hint_nxt          = LIM_W'(found_page) + LIM_W'(1);
          res_nxt.status    = ST_OK;
          res_nxt.page      = PAGE_W'(found_page);
          res_nxt.free_cnt  = COUNT_W'(free_nxt);
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
    // configuration writes are to arrive only while idle; the block does not enforce it
    if (cfg.valid) begin
      if (cfg.index == REG_PAGE_LIMIT) begin
        lim_nxt = cfg_lim;
      end else if (cfg.index == REG_HINT_START) begin
        hint_nxt = LIM_W'(cfg.data[HINT_W-1:0]);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      lim_r     <= LIM_RESET_EFF;
      hint_r    <= HINT_RESET;
      free_r    <= '0;
      total_r   <= '0;
      clr_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lim_r     <= lim_nxt;
      hint_r    <= hint_nxt;
      free_r    <= free_nxt;
      total_r   <= total_nxt;
      clr_row_r <= clr_row_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_row_r <= scan_row_nxt;
    chk_row_r  <= chk_row_nxt;
    req_r      <= req_nxt;
    page_r     <= page_nxt;
    res_r      <= res_nxt;
  end

  assign res = res_r;

endmodule

[tb/testbench.sv]
// testbench: self-checking regression for the page frame allocator core
`timescale 1ns / 1ps

module testbench;
  import pfa_pkg::*;

  // dut ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [PAGE_W-1:0]    in_page_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [PAGE_W-1:0]    out_page_out;
  logic [COUNT_W-1:0]   out_free_count;
  logic [COUNT_W-1:0]   out_total_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;

  page_frame_allocator_core dut (.*);

  always #6 clk = ~clk;

  // directed plan rows
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t            kind;
    req_t                 req;
    logic [CFG_DW-1:0]    arg;
    logic [CFG_IDX_W-1:0] idx;
    bit                   known;
    result_t              want;
  } plan_row_t;

  plan_row_t plan[$];

  // allocator shadow state
  pstate_t            page_map [NUM_PAGES];
  int unsigned        scan_hint;
  int unsigned        pages_free;
  int unsigned        pages_managed;
  logic [LIMIT_W-1:0] limit_reg;

  // results still owed by the block
  result_t pending[$];

  // run control and tallies
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int errors = 0;
  int n_sent = 0;
  int n_writes = 0;
  int n_ok = 0;
  int n_nofree = 0;
  int n_beyond = 0;
  int n_badfree = 0;

  // next result of the allocator for one request, updating the shadow state
  function automatic result_t predict_request(input req_t rq, input logic [PAGE_W-1:0] pg);
    result_t     res;
    int unsigned lim;
    int unsigned p;
    lim = (limit_reg > NUM_PAGES) ? NUM_PAGES : limit_reg;
    res.status = ST_OK;
    res.page   = pg;
    if (rq == REQ_ALLOC) begin
      p = scan_hint;
      while (p < lim && page_map[p] != PS_FREE) p++;
      if (p < lim) begin
        page_map[p] = PS_INUSE;
        pages_free--;
        scan_hint = p + 1;
        res.page  = p[PAGE_W-1:0];
      end else begin
        res.status = ST_NO_FREE;
      end
    end else if (pg >= lim) begin
      res.status = ST_BEYOND;
    end else if (rq == REQ_FREE) begin
      if (page_map[pg] != PS_INUSE) begin
        res.status = ST_NOT_INUSE;
      end else begin
        page_map[pg] = PS_FREE;
        pages_free++;
        if (pg < scan_hint) scan_hint = pg;
      end
    end else if (rq == REQ_MARK_FREE) begin
      if (page_map[pg] == PS_RESERVED || page_map[pg] == PS_KERNEL) begin
        page_map[pg] = PS_FREE;
        pages_free++;
        pages_managed++;
      end
    end else begin
      // carving out for the kernel drops the page from the counts it was in
      if (page_map[pg] == PS_FREE) begin
        pages_free--;
        pages_managed--;
      end else if (page_map[pg] == PS_INUSE) begin
        pages_managed--;
      end
      page_map[pg] = PS_KERNEL;
    end
    res.free_cnt  = pages_free[COUNT_W-1:0];
    res.total_cnt = pages_managed[COUNT_W-1:0];
    return res;
  endfunction

  // page pick: mostly inside the working window, some anywhere, some at the limit edge
  function automatic logic [PAGE_W-1:0] draw_page(input int unsigned lo, input int unsigned top);
    int unsigned k;
    int          v;
    k = $urandom_range(99, 0);
    if (top == 0 || k >= 90) return PAGE_W'($urandom_range(65535, 0));
    if (k < 80) return PAGE_W'($urandom_range(top - 1, lo));
    v = int'(top) + int'(k % 4) - 2;
    if (v > 65535) v = 65535;
    return PAGE_W'(v);
  endfunction

  // one request transfer on the input channel
  task automatic send_req(input req_t rq, input logic [PAGE_W-1:0] pg, input bit known,
                          input result_t want);
    int      gap;
    result_t got;
    gap = gaps_on ? $urandom_range(16, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rq;
    in_page_number <= pg;
    do @(posedge clk); while (!in_ready);
    got = predict_request(rq, pg);
    pending.push_back(known ? want : got);
    n_sent++;
  endtask

  // register write, only with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PAGE_LIMIT) begin
      limit_reg = val;
    end else begin
      scan_hint = val[HINT_W-1:0];
    end
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // plan builders
  task automatic add_req(input req_t rq, input logic [PAGE_W-1:0] pg);
    plan.push_back('{kind: ROW_REQ, req: rq, arg: CFG_DW'(pg), idx: '0, known: 1'b0,
                     want: result_t'(0)});
  endtask

  task automatic add_known(input req_t rq, input logic [PAGE_W-1:0] pg, input status_t st,
                           input int unsigned fc, input int unsigned tc);
    result_t w;
    w = '{status: st, page: pg, free_cnt: COUNT_W'(fc), total_cnt: COUNT_W'(tc)};
    plan.push_back('{kind: ROW_REQ, req: rq, arg: CFG_DW'(pg), idx: '0, known: 1'b1, want: w});
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    plan.push_back('{kind: ROW_CFG, req: REQ_ALLOC, arg: val, idx: idx, known: 1'b0,
                     want: result_t'(0)});
  endtask

  // random phase under one limit and hint setting
  task automatic run_phase(input int n, input logic [LIMIT_W-1:0] lim,
                           input logic [HINT_W-1:0] hint0, input int unsigned win,
                           input bit gaps);
    int unsigned lo;
    int unsigned top;
    int unsigned pick;
    int          tries;
    req_t        rq;
    logic [PAGE_W-1:0] pg;
    write_reg(REG_PAGE_LIMIT, lim);
    write_reg(REG_HINT_START, CFG_DW'(hint0));
    gaps_on = gaps;
    top = (lim > NUM_PAGES) ? NUM_PAGES : lim;
    lo  = (top > win) ? top - win : 0;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 35) rq = REQ_ALLOC;
      else if (pick < 55) rq = REQ_FREE;
      else if (pick < 85) rq = REQ_MARK_FREE;
      else rq = REQ_MARK_KERNEL;
      pg = draw_page(lo, top);
      // frees mostly go to pages actually in use
      if (rq == REQ_FREE)
        for (tries = 0; tries < 8 && page_map[pg] != PS_INUSE; tries++) pg = draw_page(lo, top);
      send_req(rq, pg, 1'b0, result_t'(0));
    end
  endtask

  // result channel: random stalls, one long hold-off on request, in-order check
  initial begin
    int      stall;
    result_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(16, 0) : 0;
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      case (status_t'(out_status))
        ST_OK:      n_ok++;
        ST_NO_FREE: n_nofree++;
        ST_BEYOND:  n_beyond++;
        default:    n_badfree++;
      endcase
      if (pending.size() == 0) begin
        $error("result transfer with nothing outstanding: page_out %0d", out_page_out);
        errors++;
      end else begin
        want = pending.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          errors++;
        end
        if (out_page_out !== want.page) begin
          $error("page_out: expected %0d, actual %0d", want.page, out_page_out);
          errors++;
        end
        if (out_free_count !== want.free_cnt) begin
          $error("free_count: expected %0d, actual %0d", want.free_cnt, out_free_count);
          errors++;
        end
        if (out_total_count !== want.total_cnt) begin
          $error("total_count: expected %0d, actual %0d", want.total_cnt, out_total_count);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    int unsigned rnd_lim;
    foreach (page_map[i]) page_map[i] = PS_RESERVED;
    scan_hint     = HINT_RESET;
    pages_free    = 0;
    pages_managed = 0;
    limit_reg     = LIMIT_RESET[LIMIT_W-1:0];

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    do @(posedge clk); while (!in_ready);

    // directed: empty map, boot marking, hint handling, kernel carve-out, limit edges
    add_known(REQ_ALLOC, 16'hFFFF, ST_NO_FREE, 0, 0);
    add_known(REQ_FREE, 16'd5, ST_NOT_INUSE, 0, 0);
    add_known(REQ_MARK_FREE, 16'hFFFF, ST_OK, 1, 1);
    add_known(REQ_MARK_FREE, 16'd0, ST_OK, 2, 2);
    add_req(REQ_MARK_FREE, 16'd300);
    add_req(REQ_MARK_FREE, 16'd300);
    add_req(REQ_ALLOC, 16'h1234);
    add_req(REQ_ALLOC, 16'd0);
    add_known(REQ_ALLOC, 16'hAAAA, ST_NO_FREE, 1, 3);
    add_req(REQ_FREE, 16'd300);
    add_known(REQ_FREE, 16'd300, ST_NOT_INUSE, 2, 3);
    add_req(REQ_MARK_KERNEL, 16'd300);
    add_req(REQ_MARK_KERNEL, 16'd300);
    add_req(REQ_MARK_FREE, 16'd300);
    add_req(REQ_ALLOC, 16'd7);
    add_req(REQ_MARK_KERNEL, 16'd300);
    add_cfg(REG_HINT_START, CFG_DW'(0));
    add_req(REQ_ALLOC, 16'h5555);
    add_req(REQ_ALLOC, 16'h0F0F);
    add_cfg(REG_PAGE_LIMIT, CFG_DW'(0));
    add_known(REQ_MARK_FREE, 16'd0, ST_BEYOND, 0, 2);
    add_known(REQ_FREE, 16'hFFFF, ST_BEYOND, 0, 2);
    add_known(REQ_MARK_KERNEL, 16'h8000, ST_BEYOND, 0, 2);
    add_known(REQ_ALLOC, 16'h00FF, ST_NO_FREE, 0, 2);
    add_cfg(REG_PAGE_LIMIT, CFG_DW'(17'h1FFFF));
    add_req(REQ_FREE, 16'hFFFF);
    add_req(REQ_FREE, 16'd0);
    add_cfg(REG_HINT_START, CFG_DW'(16'hFFFF));
    add_req(REQ_ALLOC, 16'd1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].arg);
      else send_req(plan[i].req, plan[i].arg[PAGE_W-1:0], plan[i].known, plan[i].want);
    end

    // random phases over several limit and hint settings
    run_phase(300, 17'd512, 16'd0, 512, 1'b1);
    run_phase(250, 17'd1024, 16'd700, 512, 1'b0);
    hold_cycles = 300;
    run_phase(300, 17'h10000, 16'd64512, 1024, 1'b1);
    run_phase(250, 17'h1FFFF, 16'd65000, 768, 1'b1);
    rnd_lim = $urandom_range(65536, 600);
    run_phase(200, LIMIT_W'(rnd_lim), HINT_W'(rnd_lim - 256 - $urandom_range(64, 0)), 256,
              1'b1);
    run_phase(100, 17'h10000, 16'hFFFF, 256, 1'b1);
    run_phase(50, 17'd20, 16'd0, 20, 1'b1);

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Summary: %0d requests, %0d register writes, 7 random limit/hint settings",
             n_sent, n_writes);
    $display("Summary: %0d ok, %0d no free page, %0d beyond limit, %0d bad frees",
             n_ok, n_nofree, n_beyond, n_badfree);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[page_frame_allocator_core.f]
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_state_ram.sv
hw/rtl/pfa_row_find.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/page_frame_allocator_core.sv
tb/testbench.sv
